[design/dqu_pkg.sv]
// ----------------------------------------------------------------------------
// dqu_pkg - shared types and constants of the double-ended queue unit
// Operation and status codes, sizes and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package dqu_pkg;

	localparam int DEPTH       = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int OCC_W       = 5;
	localparam int OUT_TDATA_W = ((WORD_W + OCC_W + 7) / 8) * 8;
	localparam int PAD_W       = OUT_TDATA_W - WORD_W - OCC_W;

	localparam logic [WORD_W-1:0] POP_EMPTY_WORD = '1;

	typedef enum logic [1:0] {
		KIND_PUSH_REAR  = 2'd0,
		KIND_PUSH_FRONT = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic              shift_back;  // push front: every cell takes its front neighbour
		logic              shift_fwd;   // pop front: every cell takes its rear neighbour
		logic              wr_en;       // push rear: the cell at wr_idx takes the word
		logic [IDX_W-1:0]  wr_idx;
		logic [IDX_W-1:0]  rd_idx;      // cell whose word is put on the tap bus
		logic [WORD_W-1:0] value;
	} cell_cmd_t;

endpackage

[design/dqu_cell.sv]
// ----------------------------------------------------------------------------
// dqu_cell - one storage cell of the queue row
// Holds one word; shifts towards either neighbour or loads the pushed word.
// ----------------------------------------------------------------------------
module dqu_cell (
	input  logic                         clk,
	input  dqu_pkg::cell_cmd_t           cmd,
	input  logic [dqu_pkg::IDX_W-1:0]    idx,
	input  logic [dqu_pkg::WORD_W-1:0]   front_data,
	input  logic [dqu_pkg::WORD_W-1:0]   rear_data,
	output logic [dqu_pkg::WORD_W-1:0]   data,
	output logic [dqu_pkg::WORD_W-1:0]   tap
);
	import dqu_pkg::*;

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_back) begin
			data_q <= front_data;
		end else if (cmd.shift_fwd) begin
			data_q <= rear_data;
		end else if (cmd.wr_en && (cmd.wr_idx == idx)) begin
			data_q <= cmd.value;
		end
	end

	assign data = data_q;
	// zero unless selected, so the row can be OR-reduced
	assign tap  = (cmd.rd_idx == idx) ? data_q : '0;

endmodule

[design/double_ended_queue_unit.sv]
// A result beat appears on the master side in the cycle after its input beat is accepted.
// Throughput: one operation per cycle; a result beat held by a stalled master
// holds the slave side until the master takes it.
// The rate is set by the shift of the cell row and the tap bus read.
// Reset (arst_n low, asynchronous): queue empty, no result pending.
// Cell contents are not reset; a cell is only read after a push has written it.
// ----------------------------------------------------------------------------
// double_ended_queue_unit - bounded double-ended queue of 32-bit words
// A row of cells with the front at cell 0. Front push/pop shift the whole row,
// rear push writes the cell just past the rear, rear pop reads the last occupied cell.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dqu_pkg::WORD_W-1:0]         s_tdata,   // [31:0] value
	input  logic [1:0]                         s_tuser,   // [1:0] kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dqu_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] popped, [36:32] occupancy
	output logic [1:0]                         m_tuser    // [1:0] status
);
	import dqu_pkg::*;

	// fill count and output register
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              out_valid_q;
	logic [WORD_W-1:0] popped_q;
	logic [WORD_W-1:0] popped_d;
	status_t           status_q;
	status_t           status_d;
	logic [OCC_W-1:0]  occ_q;

	logic      accept;
	logic      full;
	logic      empty;
	kind_t     kind;
	cell_cmd_t cmd;

	// cell row wiring
	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [WORD_W-1:0] cell_tap  [DEPTH];
	logic [WORD_W-1:0] tap_or;

	// free to take a beat whenever the output register empties this cycle
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	// decode the beat into a row command, the next count and the result
	always_comb begin
		cmd            = '0;
		cmd.value      = s_tdata;
		cmd.wr_idx     = count_q[IDX_W-1:0];
		cmd.rd_idx     = '0;
		count_d        = count_q;
		popped_d       = '0;
		status_d       = ST_OK;
		case (kind)
			KIND_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.wr_en = accept;
					count_d   = count_q + CNT_W'(1);
				end
			end
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.shift_back = accept;
					count_d        = count_q + CNT_W'(1);
				end
			end
			KIND_POP_FRONT: begin
				cmd.rd_idx = '0;
				if (empty) begin
					status_d = ST_EMPTY;
					popped_d = POP_EMPTY_WORD;
				end else begin
					cmd.shift_fwd = accept;
					popped_d      = tap_or;
					count_d       = count_q - CNT_W'(1);
				end
			end
			KIND_POP_REAR: begin
				// last stored word sits at count - 1
				cmd.rd_idx = IDX_W'(count_q - CNT_W'(1));
				if (empty) begin
					status_d = ST_EMPTY;
					popped_d = POP_EMPTY_WORD;
				end else begin
					popped_d = tap_or;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// the row: cell 0 is the front; a front push feeds the word into cell 0,
	// a front pop feeds zero into the last cell
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_W-1:0] front_in;
		logic [WORD_W-1:0] rear_in;

		if (g == 0) begin : g_first
			assign front_in = s_tdata;
		end else begin : g_mid
			assign front_in = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rear_in = '0;
		end else begin : g_inner
			assign rear_in = cell_data[g+1];
		end

		dqu_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (IDX_W'(g)),
			.front_data (front_in),
			.rear_data  (rear_in),
			.data       (cell_data[g]),
			.tap        (cell_tap[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, occ_q, popped_q};
	assign m_tuser  = status_q;

endmodule

[design/dqu_checker.sv]
// ----------------------------------------------------------------------------
// dqu_checker - port-level checks of the double-ended queue unit
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module dqu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [dqu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input logic [1:0]                         m_tuser
);
	import dqu_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// every accepted beat gives a result beat in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result beat after accepted input");

	// a refused push only happens at full occupancy, with a zero word
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |->
			(m_tdata[36:32] == OCC_W'(DEPTH)) && (m_tdata[31:0] == '0))
		else $error("full status with wrong occupancy or word");

	// a refused pop leaves the queue empty and returns all ones
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |->
			(m_tdata[36:32] == '0) && (m_tdata[31:0] == POP_EMPTY_WORD))
		else $error("empty status with wrong occupancy or word");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the double-ended queue unit
// Directed corner operations, then random fill/drain phases against a shadow
// ring of words; every result beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import dqu_pkg::*;

	localparam int RANDOM_OPS  = 1330;
	localparam int IDLE_LIMIT  = 4000;  // cycles with no beat on either side
	localparam int LONG_HOLD   = 96;    // receiver hold-off, well past the buffering
	localparam int SETTLE_CYC  = 16;

	typedef struct {
		kind_t             kind;
		logic [WORD_W-1:0] value;
		bit                drain_first;  // sender waits for every result first
	} deque_op_t;

	typedef struct {
		logic [WORD_W-1:0] popped;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [WORD_W-1:0]      s_tdata  = '0;
	logic [1:0]             s_tuser  = KIND_PUSH_REAR;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;

	double_ended_queue_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	deque_op_t     pending_ops[$];
	deque_result_t predicted_results[$];

	// shadow copy of the queue
	logic [WORD_W-1:0] shadow_words [DEPTH];
	int                shadow_head = 0;
	int                shadow_tail = 0;
	int                shadow_fill = 0;

	// bookkeeping; beat counters move by NBA so either side reads settled values
	int beats_in   = 0;
	int beats_out  = 0;
	bit all_sent   = 1'b0;
	int fail_count = 0;
	int kind_count [4] = '{default: 0};
	int full_refusals  = 0;
	int empty_refusals = 0;
	int peak_fill      = 0;

	// Works out the result of one operation and steps the shadow queue.
	function automatic void predict_op(input kind_t kind, input logic [WORD_W-1:0] word);
		deque_result_t r;
		r.popped = '0;
		r.status = ST_OK;
		case (kind)
			KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
				if (shadow_fill == DEPTH) begin
					r.status = ST_FULL;
					full_refusals++;
				end else if (kind == KIND_PUSH_REAR) begin
					shadow_words[shadow_tail] = word;
					shadow_tail = (shadow_tail + 1) % DEPTH;
					shadow_fill++;
				end else begin
					// head steps back, wrapping below zero
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_words[shadow_head] = word;
					shadow_fill++;
				end
			end
			default: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
					r.popped = POP_EMPTY_WORD;
					empty_refusals++;
				end else if (kind == KIND_POP_FRONT) begin
					r.popped = shadow_words[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end else begin
					shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
					r.popped = shadow_words[shadow_tail];
					shadow_fill--;
				end
			end
		endcase
		r.occupancy = OCC_W'(shadow_fill);
		predicted_results.push_back(r);
		kind_count[kind]++;
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		if ($urandom_range(7) != 0)
			return $urandom();
		case ($urandom_range(3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: slave side, bursts of beats separated by random gaps
	// ------------------------------------------------------------------------
	int        burst_left;
	int        gap_left;
	bit        s_fire;
	deque_op_t next_op;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= KIND_PUSH_REAR;
			beats_in   <= 0;
			all_sent   <= 1'b0;
			burst_left = 20;
			gap_left   = 0;
		end else begin
			s_fire = s_tvalid && s_tready;
			if (s_fire) begin
				predict_op(kind_t'(s_tuser), s_tdata);
				beats_in <= beats_in + 1;
				if (pending_ops.size() == 0)
					all_sent <= 1'b1;
			end
			if (!s_tvalid || s_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_ops[0].drain_first && (s_fire || beats_in != beats_out)) begin
					// pause until the block has handed back everything
					s_tvalid <= 1'b0;
				end else begin
					next_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_op.value;
					s_tuser  <= next_op.kind;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(3) == 0) begin
							burst_left = $urandom_range(150, 60);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(24, 1);
							gap_left   = $urandom_range(7, 1);
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: master side, checks each result beat and drives the stall pattern
	// ------------------------------------------------------------------------
	deque_result_t  want;
	logic [15:0]    stall_pattern;
	int             pattern_pos;
	int             pattern_age;
	int             hold_left;
	int             next_hold_at;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			beats_out     <= 0;
			stall_pattern = '1;
			pattern_pos   = 0;
			pattern_age   = 0;
			hold_left     = 0;
			next_hold_at  = 300;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_out <= beats_out + 1;
				if (predicted_results.size() == 0) begin
					$error("result beat with no operation outstanding");
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (m_tdata[WORD_W-1:0] !== want.popped) begin
						$error("popped: expected %0d, got %0d",
							$signed(want.popped), $signed(m_tdata[WORD_W-1:0]));
						fail_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						fail_count++;
					end
					if (m_tdata[WORD_W +: OCC_W] !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, m_tdata[WORD_W +: OCC_W]);
						fail_count++;
					end
				end
			end

			// long hold-off twice in the run, so the block backs up into its input
			if (hold_left == 0 && beats_in >= next_hold_at) begin
				hold_left    = LONG_HOLD;
				next_hold_at = (next_hold_at < 900) ? 900 : 32'h7fff_ffff;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				// fresh pattern each time pattern_age wraps; a third of them never stall
				if (pattern_age == 63) begin
					pattern_age = 0;
					case ($urandom_range(2))
						0:       stall_pattern = '1;
						1:       stall_pattern = 16'($urandom());
						default: stall_pattern = 16'($urandom() & $urandom());
					endcase
					if (stall_pattern == '0)
						stall_pattern = 16'h0001;
				end else begin
					pattern_age++;
				end
				m_tready    <= stall_pattern[pattern_pos];
				pattern_pos = (pattern_pos + 1) % 16;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run if no beat moves on either side for too long
	// ------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("double_ended_queue_unit regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		deque_op_t op;
		int        phase_left;
		int        push_pct;

		op.drain_first = 1'b0;

		// empty pops from both ends
		op.value = 32'hffff_ffff;
		op.kind  = KIND_POP_FRONT;
		pending_ops.push_back(op);
		op.kind  = KIND_POP_REAR;
		pending_ops.push_back(op);

		// fill to the brim from both ends; the first front push wraps the head
		for (int i = 0; i < DEPTH; i++) begin
			op.kind = (i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
			case (i)
				0:       op.value = 32'h7fff_ffff;
				1:       op.value = 32'h8000_0000;
				2:       op.value = 32'h0000_0000;
				3:       op.value = 32'hffff_ffff;
				default: op.value = (i % 2) ? (32'haaaa_aaaa ^ i) : (32'h5555_5555 + i);
			endcase
			pending_ops.push_back(op);
		end

		// refused pushes on a full queue
		op.value = 32'h1234_5678;
		op.kind  = KIND_PUSH_REAR;
		pending_ops.push_back(op);
		op.kind  = KIND_PUSH_FRONT;
		pending_ops.push_back(op);

		// pops from both ends, pop value must be ignored
		op.value = 32'hdead_beef;
		op.kind  = KIND_POP_FRONT;
		pending_ops.push_back(op);
		op.kind  = KIND_POP_REAR;
		pending_ops.push_back(op);
		op.kind  = KIND_POP_FRONT;
		pending_ops.push_back(op);
		op.kind  = KIND_POP_REAR;
		pending_ops.push_back(op);

		// random phases biased to fill, to drain, or balanced
		phase_left = 0;
		push_pct   = 50;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(60, 20);
				case ($urandom_range(2))
					0:       push_pct = 85;
					1:       push_pct = 15;
					default: push_pct = 50;
				endcase
			end
			phase_left--;
			op.drain_first = (i == 400 || i == 1000);
			if ($urandom_range(99) < push_pct)
				op.kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
			else
				op.kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR;
			op.value = pick_word();
			pending_ops.push_back(op);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (!(all_sent && beats_in == beats_out));
		repeat (SETTLE_CYC) @(posedge clk);

		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_results.size());
			fail_count++;
		end

		$display("ran %0d ops: %0d push rear, %0d push front, %0d pop front, %0d pop rear",
			beats_in, kind_count[KIND_PUSH_REAR], kind_count[KIND_PUSH_FRONT],
			kind_count[KIND_POP_FRONT], kind_count[KIND_POP_REAR]);
		$display("refused on full %0d, refused on empty %0d, peak fill %0d of %0d",
			full_refusals, empty_refusals, peak_fill, DEPTH);
		if (fail_count == 0)
			$display("double_ended_queue_unit regression: pass");
		else
			$display("double_ended_queue_unit regression: fail");
		$finish;
	end

endmodule

[sim.f]
design/dqu_pkg.sv
design/dqu_cell.sv
design/double_ended_queue_unit.sv
design/dqu_checker.sv
tb/sv/tb_top.sv
